[rtl/two_stacks_shared_memory_top_macros.svh]
// assertion macros for the two-stack block checker
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef TWO_STACKS_SHARED_MEMORY_TOP_MACROS_SVH
`define TWO_STACKS_SHARED_MEMORY_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define TSSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("two-stack check failed");

// next-cycle implication, disabled while reset is held
`define TSSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("two-stack check failed");

`endif

[rtl/tssm_pkg.sv]
// shared types and constants for the two-stack block
// no dependencies
package tssm_pkg;

    localparam int MAX_DEPTH  = 256;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W     = $clog2(MAX_DEPTH);
    localparam int SIZE_W     = 9;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // byte address of the size_in_use register
    localparam logic [APB_ADDR_W-1:0] CFG_ADDR_SIZE = '0;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic               stack_select;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] data_out;
        t_status            status;
        logic [8:0]         stack_count;
        logic               is_full;
        logic               is_empty;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

[rtl/tssm_ctrl.sv]
// sequencing state machine for the two-stack block
// depends on tssm_pkg
module tssm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tssm_pkg::t_dp_cmd o_dp_cmd
);
    import tssm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   w_accept;

    assign w_accept      = (r_state == S_IDLE) && i_in_valid && !r_in_stall;
    assign o_in_stall    = r_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_dp_cmd.load = w_accept;
    assign o_dp_cmd.exec = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state    <= S_EXEC;
                        r_in_stall <= 1'b1;
                    end else begin
                        r_in_stall <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/tssm_datapath.sv]
// counts, size register, shared stack memory and result register
// depends on tssm_pkg
module tssm_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tssm_pkg::t_dp_cmd       i_dp_cmd,
    input  tssm_pkg::t_in_item      i_in_item,
    input  logic                    i_cfg_wr,
    input  logic [tssm_pkg::SIZE_W-1:0] i_cfg_size,
    output logic [tssm_pkg::SIZE_W-1:0] o_cfg_size,
    output tssm_pkg::t_out_item     o_out_item
);
    import tssm_pkg::*;

    logic [DATA_W-1:0] r_mem [MAX_DEPTH];

    t_in_item          r_item;
    logic [SIZE_W-1:0] r_size_raw;
    logic [CNT_W-1:0]  r_low;
    logic [CNT_W-1:0]  r_high;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_used;
    t_status           r_status;
    logic [CNT_W-1:0]  r_count;
    logic              r_full;
    logic              r_empty;

    logic [CNT_W-1:0]  w_size;
    logic [CNT_W-1:0]  w_cnt;
    logic              w_full;
    logic [CNT_W-1:0]  n_low;
    logic [CNT_W-1:0]  n_high;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W:0]    n_sum;
    t_status           n_status;
    logic              w_we;
    logic              w_re;
    logic [CNT_W-1:0]  w_addr;

    // effective size: zero acts as one, oversize acts as full depth
    always_comb begin
        if (r_size_raw == '0) begin
            w_size = CNT_W'(1);
        end else if (CNT_W'(r_size_raw) > CNT_W'(MAX_DEPTH)) begin
            w_size = CNT_W'(MAX_DEPTH);
        end else begin
            w_size = CNT_W'(r_size_raw);
        end
    end

    assign w_cnt  = r_item.stack_select ? r_high : r_low;
    assign w_full = ({1'b0, r_low} + {1'b0, r_high}) >= {1'b0, w_size};

    always_comb begin
        n_low    = r_low;
        n_high   = r_high;
        n_status = ST_OK;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_addr   = '0;
        unique case (r_item.command)
            CMD_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (r_item.push_value == '0) begin
                    n_status = ST_ZERO;
                end else begin
                    w_we = 1'b1;
                    if (r_item.stack_select) begin
                        n_high = r_high + CNT_W'(1);
                        w_addr = w_size - n_high;
                    end else begin
                        n_low  = r_low + CNT_W'(1);
                        w_addr = r_low;
                    end
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (w_cnt == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re = 1'b1;
                    if (r_item.stack_select) begin
                        w_addr = w_size - r_high;
                        if (r_item.command == CMD_POP) begin
                            n_high = r_high - CNT_W'(1);
                        end
                    end else begin
                        w_addr = r_low - CNT_W'(1);
                        if (r_item.command == CMD_POP) begin
                            n_low = r_low - CNT_W'(1);
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                if (r_item.stack_select) begin
                    n_high = '0;
                end else begin
                    n_low = '0;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        n_cnt = r_item.stack_select ? n_high : n_low;
        n_sum = {1'b0, n_low} + {1'b0, n_high};
    end

    // memory port: at most one write or one registered read per command
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec && w_we) begin
            r_mem[w_addr[ADDR_W-1:0]] <= r_item.push_value;
        end
        if (i_dp_cmd.exec && w_re) begin
            r_rd_data <= r_mem[w_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_dp_cmd.exec) begin
            r_rd_used <= w_re;
            r_status  <= n_status;
            r_count   <= n_cnt;
            r_full    <= n_sum >= {1'b0, w_size};
            r_empty   <= (n_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_raw <= SIZE_W'(MAX_DEPTH);
            r_low      <= '0;
            r_high     <= '0;
        end else if (i_cfg_wr) begin
            r_size_raw <= i_cfg_size;
            r_low      <= '0;
            r_high     <= '0;
        end else if (i_dp_cmd.exec) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    assign o_cfg_size             = r_size_raw;
    assign o_out_item.data_out    = r_rd_used ? r_rd_data : '0;
    assign o_out_item.status      = r_status;
    assign o_out_item.stack_count = r_count;
    assign o_out_item.is_full     = r_full;
    assign o_out_item.is_empty    = r_empty;

endmodule

[rtl/two_stacks_shared_memory_top.sv]
// two LIFO stacks in one shared 256-word memory, top level
// depends on tssm_pkg, tssm_ctrl, tssm_datapath
//
// usage
//   input channel (i_in_valid, o_in_stall, i_in_item): one command per
//   transfer: push, pop, peek or clear, for the low or the high stack
//   output channel (o_out_valid, i_out_stall, o_out_item): one result per
//   command with popped or peeked data, status, count and full/empty flags
//   apb port: register 0 is size_in_use (words shared by both stacks);
//   any write to it also empties both stacks
//   timing: a command is taken in idle, executes in the next cycle (one
//   memory write or one registered memory read) and its result shows the
//   cycle after that
//   sequencing: one command at a time, with a single memory port shared
//   by both stacks
//   stall: the result register holds its value while i_out_stall is high
//   and no new command is taken until the result transfer completes
//   reset: counts clear, size goes to 256, o_in_stall is high for the first
//   cycle after reset; memory contents are left as they are
module two_stacks_shared_memory_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tssm_pkg::t_in_item              i_in_item,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tssm_pkg::t_out_item             o_out_item,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tssm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tssm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tssm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tssm_pkg::*;

    t_dp_cmd           w_dp_cmd;
    logic              w_cfg_wr;
    logic [SIZE_W-1:0] w_cfg_size;

    // single register at byte address 0
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready && (paddr == CFG_ADDR_SIZE);
    assign prdata     = APB_DATA_W'(w_cfg_size);

    tssm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (w_dp_cmd)
    );

    tssm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_cmd   (w_dp_cmd),
        .i_in_item  (i_in_item),
        .i_cfg_wr   (w_cfg_wr),
        .i_cfg_size (pwdata[SIZE_W-1:0]),
        .o_cfg_size (w_cfg_size),
        .o_out_item (o_out_item)
    );

endmodule

[rtl/tssm_checker.sv]
// port-level checks for the two-stack block, bound to the top level
// depends on tssm_pkg and two_stacks_shared_memory_top_macros.svh
`include "two_stacks_shared_memory_top_macros.svh"

module tssm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input tssm_pkg::t_out_item             o_out_item
);
    import tssm_pkg::*;

    logic w_empty_res;

    assign w_empty_res = o_out_valid && (o_out_item.status == ST_EMPTY);

    // a held result stays offered
    `TSSM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // empty flag agrees with the reported count
    `TSSM_ASSERT_NOW(a_empty_flag, o_out_valid, o_out_item.is_empty == (o_out_item.stack_count == '0))

    // an empty pop or peek returns no data
    `TSSM_ASSERT_NOW(a_empty_data, w_empty_res, o_out_item.data_out == '0 && o_out_item.is_empty)

    // one command in flight: a transfer blocks the next one
    `TSSM_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall && !o_out_valid)

endmodule

bind two_stacks_shared_memory_top tssm_checker u_tssm_checker (.*);
